[rtl/core/sfp_pkg.sv]
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame parser.
package sfp_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'hAA;

  // Configuration register indexes.
  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  // Input flag carried in tuser.
  localparam logic ACTION_BYTE    = 1'b0;
  localparam logic ACTION_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT_H1  = 3'd0,
    PH_WAIT_H2  = 3'd1,
    PH_TYPE     = 3'd2,
    PH_LEN      = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CRC      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CRC_OK  = 2'd1,
    KIND_CRC_BAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] received_crc;
    logic [7:0]  payload_length;
    logic [7:0]  msg_type;
    logic [7:0]  byte_index;
    logic [7:0]  payload_byte;
    kind_t       kind;
  } result_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/sfp_in_reg.sv]
// Input register that holds one received request until the parser takes it.
module sfp_in_reg
  import sfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       take,
  output logic       item_valid,
  output logic       item_action,
  output logic [7:0] item_byte
);

  logic       valid;
  logic       action;
  logic [7:0] rx_byte;

  assign s_tready    = !valid || take;
  assign item_valid  = valid;
  assign item_action = action;
  assign item_byte   = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      action  <= s_tuser;
      rx_byte <= s_tdata;
    end
  end

endmodule

[rtl/core/sfp_parser.sv]
// Frame parser state machine with the running CRC and result generation.
module sfp_parser
  import sfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       action,
  input  logic [7:0] rx_byte,
  input  logic [7:0] header_first,
  input  logic [7:0] header_second,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic        crc_byte_count, crc_byte_count_next;
  logic [15:0] crc_step;
  logic [15:0] crc_restart;
  logic [15:0] rx_crc;

  assign crc_step    = crc_add(running_crc, rx_byte);
  assign crc_restart = crc_add(CRC_INIT, rx_byte);
  assign rx_crc      = {crc_high_byte, rx_byte};

  // Next state.
  always_comb begin
    phase_next          = phase;
    frame_type_next     = frame_type;
    frame_length_next   = frame_length;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    crc_high_byte_next  = crc_high_byte;
    crc_byte_count_next = crc_byte_count;
    if (action == ACTION_TIMEOUT) begin
      phase_next          = PH_WAIT_H1;
      frame_type_next     = '0;
      frame_length_next   = '0;
      payload_count_next  = '0;
      running_crc_next    = CRC_INIT;
      crc_high_byte_next  = '0;
      crc_byte_count_next = 1'b0;
    end else begin
      case (phase)
        PH_WAIT_H1: begin
          if (rx_byte == header_first) begin
            running_crc_next = crc_restart;
            phase_next       = PH_WAIT_H2;
          end
        end
        PH_WAIT_H2: begin
          if (rx_byte == header_second) begin
            running_crc_next = crc_step;
            phase_next       = PH_TYPE;
          end else if (rx_byte == header_first) begin
            running_crc_next = crc_restart;
          end else begin
            phase_next       = PH_WAIT_H1;
            frame_type_next  = '0;
            frame_length_next = '0;
            payload_count_next = '0;
            running_crc_next = CRC_INIT;
            crc_high_byte_next = '0;
            crc_byte_count_next = 1'b0;
          end
        end
        PH_TYPE: begin
          frame_type_next  = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          frame_length_next   = rx_byte;
          running_crc_next    = crc_step;
          payload_count_next  = '0;
          crc_byte_count_next = 1'b0;
          phase_next          = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_crc_next   = crc_step;
          payload_count_next = payload_count + 8'd1;
          if (payload_count_next == frame_length) begin
            crc_byte_count_next = 1'b0;
            phase_next          = PH_CRC;
          end
        end
        PH_CRC: begin
          if (!crc_byte_count) begin
            crc_high_byte_next  = rx_byte;
            crc_byte_count_next = 1'b1;
          end else begin
            phase_next          = PH_WAIT_H1;
            frame_type_next     = '0;
            frame_length_next   = '0;
            payload_count_next  = '0;
            running_crc_next    = CRC_INIT;
            crc_high_byte_next  = '0;
            crc_byte_count_next = 1'b0;
          end
        end
        default: begin
          phase_next          = PH_WAIT_H1;
          frame_type_next     = '0;
          frame_length_next   = '0;
          payload_count_next  = '0;
          running_crc_next    = CRC_INIT;
          crc_high_byte_next  = '0;
          crc_byte_count_next = 1'b0;
        end
      endcase
    end
  end

  // Result for the byte now being parsed.
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.payload_byte   = '0;
    res.byte_index     = '0;
    res.msg_type       = frame_type;
    res.payload_length = frame_length;
    res.received_crc   = '0;
    if (action == ACTION_BYTE) begin
      case (phase)
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = rx_byte;
          res.byte_index   = payload_count;
        end
        PH_CRC: begin
          if (crc_byte_count) begin
            res_valid        = 1'b1;
            res.kind         = (rx_crc == running_crc) ? KIND_CRC_OK : KIND_CRC_BAD;
            res.received_crc = rx_crc;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT_H1;
      frame_type     <= '0;
      frame_length   <= '0;
      payload_count  <= '0;
      running_crc    <= CRC_INIT;
      crc_high_byte  <= '0;
      crc_byte_count <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      frame_type     <= frame_type_next;
      frame_length   <= frame_length_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      crc_high_byte  <= crc_high_byte_next;
      crc_byte_count <= crc_byte_count_next;
    end
  end

`ifndef SYNTHESIS
  // Idle parser always holds a fresh CRC and no payload progress.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WAIT_H1 |-> running_crc == CRC_INIT && payload_count == 8'd0)
    else $error("parser idle with stale CRC or count");

  a_timeout_resets: assert property (@(posedge clk) disable iff (rst)
    fire && action == ACTION_TIMEOUT |=> phase == PH_WAIT_H1)
    else $error("timeout did not return parser to header search");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == PH_PAYLOAD || phase == PH_CRC)
    else $error("result produced outside payload or CRC phase");

  // The payload phase is left exactly when the declared length is reached.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_count < frame_length)
    else $error("payload count overran declared length");
`endif

endmodule

[rtl/core/sfp_out_reg.sv]
// Result register that drives the master-side stream.
module sfp_out_reg
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [1:0]  m_tuser
);

  logic    valid;
  result_t data;

  assign m_tvalid = valid;
  assign m_tdata  = {data.received_crc, data.payload_length, data.msg_type,
                     data.byte_index, data.payload_byte};
  assign m_tuser  = data.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

[rtl/core/serial_frame_parser_crc16.sv]
// Top level of the serial frame parser with CRC-16/CCITT-FALSE check.
// Path: a request waits in the input register until the result register is free or draining.
// Throughput: one byte or timeout request per cycle while the result stream is not stalled; the
// parser step, one byte-wide CRC update between the input and result registers, sets that figure.
// Reset (rst, synchronous): parser returns to header search, CRC to 0xFFFF, headers to 0x55/0xAA.
module serial_frame_parser_crc16
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] byte_index, [23:16] msg_type,
  // [31:24] payload_length, [47:32] received_crc
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       header_first;
  logic [7:0] header_first_reg;
  logic [7:0] header_second_reg;
  logic       item_valid;
  logic       item_action;
  logic [7:0] item_byte;
  logic       fire;
  logic       res_valid;
  result_t    res;

  assign cfg_ready    = 1'b1;
  assign header_first = (cfg_index == CFG_HEADER_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first_reg  <= HEADER_FIRST_RESET;
      header_second_reg <= HEADER_SECOND_RESET;
    end else if (cfg_valid) begin
      if (header_first) begin
        header_first_reg <= cfg_data;
      end else begin
        header_second_reg <= cfg_data;
      end
    end
  end

  // The held request moves on whenever the result register is free or draining.
  assign fire = item_valid && (!m_axis_tvalid || m_axis_tready);

  sfp_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .take        (fire),
    .item_valid  (item_valid),
    .item_action (item_action),
    .item_byte   (item_byte)
  );

  sfp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .action        (item_action),
    .rx_byte       (item_byte),
    .header_first  (header_first_reg),
    .header_second (header_second_reg),
    .res_valid     (res_valid),
    .res           (res)
  );

  sfp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

[tb/serial_frame_parser_crc16_tb.sv]
// Self-checking testbench for the serial frame parser: frame traffic in, predicted results out.
`timescale 1ns / 100ps

module serial_frame_parser_crc16_tb;
  import sfp_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int WHOLE       = 1 << 16;
  localparam int MAX_PRINTS  = 40;

  // Tracks the parser state and queues the results each accepted request should produce.
  class frame_scoreboard;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    phase_t      phase;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic [7:0]  pcount;
    logic [7:0]  crc_hi;
    logic [15:0] crc;
    bit          crc_half;
    result_t     expected_q[$];
    int          errors;

    function new();
      hdr_first  = HEADER_FIRST_RESET;
      hdr_second = HEADER_SECOND_RESET;
      errors     = 0;
      clear();
    endfunction

    // Bit-serial form of the CRC-16/CCITT-FALSE update, MSB of the byte first.
    static function logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void clear();
      phase    = PH_WAIT_H1;
      ftype    = '0;
      flen     = '0;
      pcount   = '0;
      crc      = CRC_INIT;
      crc_hi   = '0;
      crc_half = 1'b0;
    endfunction

    function void set_register(input logic idx, input logic [7:0] value);
      if (idx == CFG_HEADER_FIRST) begin
        hdr_first = value;
      end else begin
        hdr_second = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(input logic act, input logic [7:0] b);
      result_t r;
      r = '0;
      if (act == ACTION_TIMEOUT) begin
        clear();
        return;
      end
      case (phase)
        PH_WAIT_H1: begin
          if (b == hdr_first) begin
            crc   = crc16_byte(CRC_INIT, b);
            phase = PH_WAIT_H2;
          end
        end
        PH_WAIT_H2: begin
          // The second-header test wins when both headers are equal.
          if (b == hdr_second) begin
            crc   = crc16_byte(crc, b);
            phase = PH_TYPE;
          end else if (b == hdr_first) begin
            crc = crc16_byte(CRC_INIT, b);
          end else begin
            clear();
          end
        end
        PH_TYPE: begin
          ftype = b;
          crc   = crc16_byte(crc, b);
          phase = PH_LEN;
        end
        PH_LEN: begin
          flen     = b;
          crc      = crc16_byte(crc, b);
          pcount   = '0;
          crc_half = 1'b0;
          phase    = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          r.kind           = KIND_PAYLOAD;
          r.payload_byte   = b;
          r.byte_index     = pcount;
          r.msg_type       = ftype;
          r.payload_length = flen;
          expected_q.push_back(r);
          crc    = crc16_byte(crc, b);
          pcount = pcount + 8'd1;
          if (pcount == flen) begin
            crc_half = 1'b0;
            phase    = PH_CRC;
          end
        end
        PH_CRC: begin
          if (!crc_half) begin
            crc_hi   = b;
            crc_half = 1'b1;
          end else begin
            r.received_crc   = {crc_hi, b};
            r.kind           = (r.received_crc == crc) ? KIND_CRC_OK : KIND_CRC_BAD;
            r.msg_type       = ftype;
            r.payload_length = flen;
            expected_q.push_back(r);
            clear();
          end
        end
        default: clear();
      endcase
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
    endtask

    task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
        report($sformatf("%s got %h expected %h", name, got, want));
      end
    endtask

    task check_result(input logic [47:0] data, input logic [1:0] user);
      result_t got;
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result tdata %h tuser %h", data, user));
        return;
      end
      want = expected_q.pop_front();
      got  = {data, user};
      check_field("kind", 16'(got.kind), 16'(want.kind));
      check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      check_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
      check_field("msg_type", 16'(got.msg_type), 16'(want.msg_type));
      check_field("payload_length", 16'(got.payload_length), 16'(want.payload_length));
      check_field("received_crc", got.received_crc, want.received_crc);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  frame_scoreboard board;
  logic [7:0]      cur_h1 = HEADER_FIRST_RESET;
  logic [7:0]      cur_h2 = HEADER_SECOND_RESET;
  int              items_sent = 0;
  bit              calm = 1'b0;
  bit              hold_req = 1'b0;

  serial_frame_parser_crc16 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one request, with random gaps in front unless the run is in a calm stretch.
  task automatic send_item(input logic act, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(act, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACTION_BYTE, b);
  endtask

  task automatic send_timeout();
    send_item(ACTION_TIMEOUT, 8'($urandom));
  endtask

  // Sends the first keep bytes of a frame; a cut frame may be followed by a timeout.
  task automatic send_frame(input logic [7:0] ftype, input int len, input bit bad_crc,
                            input int fill, input int keep, input bit abort);
    logic [7:0]  frame_q[$];
    logic [15:0] sum;
    frame_q = {cur_h1, cur_h2, ftype, 8'(len)};
    for (int i = 0; i < len; i++) begin
      frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    sum = CRC_INIT;
    foreach (frame_q[i]) sum = frame_scoreboard::crc16_byte(sum, frame_q[i]);
    if (bad_crc) begin
      sum ^= 16'(1) << $urandom_range(15);
    end
    frame_q.push_back(sum[15:8]);
    frame_q.push_back(sum[7:0]);
    foreach (frame_q[i]) begin
      if (i < keep) begin
        send_byte(frame_q[i]);
      end
    end
    if (abort && keep < frame_q.size()) begin
      send_timeout();
    end
  endtask

  task automatic random_burst();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(39) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
    if (pick < 60) begin
      send_frame(8'($urandom), len, $urandom_range(5) == 0, -1, WHOLE, 1'b0);
    end else if (pick < 72) begin
      send_frame(8'($urandom), len, 1'b0, -1, $urandom_range(1, len + 5),
                 $urandom_range(3) != 0);
    end else if (pick < 80) begin
      send_byte(cur_h1);
      send_frame(8'($urandom), len, $urandom_range(5) == 0, -1, WHOLE, 1'b0);
    end else if (pick < 86) begin
      send_timeout();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_byte($urandom_range(2) == 0 ? cur_h1 : 8'($urandom));
      end
    end
  endtask

  task automatic random_traffic(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) random_burst();
  endtask

  // Stops offering and waits until no expected result is outstanding, then lets the design settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, value);
  endtask

  task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
    write_reg(CFG_HEADER_FIRST, h1);
    write_reg(CFG_HEADER_SECOND, h2);
    cfg_valid <= 1'b0;
    cur_h1 = h1;
    cur_h2 = h2;
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int held;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        board.check_result(m_axis_tdata, m_axis_tuser);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    board = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACTION_BYTE;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_HEADER_FIRST;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames with the reset headers.
    send_timeout();
    send_byte(cur_h1);
    send_frame(8'hFF, 0, 1'b0, -1, WHOLE, 1'b0);
    send_byte(cur_h1);
    send_byte(8'h00);
    send_frame(8'h00, 1, 1'b1, 255, WHOLE, 1'b0);
    send_byte(cur_h1);
    send_timeout();
    send_frame(8'h12, 2, 1'b0, -1, 5, 1'b1);

    // The receiver holds off while requests keep coming, so the input backs up.
    hold_req = 1'b1;
    random_traffic(300);
    drain();

    set_headers(8'h00, 8'hFF);
    calm = 1'b1;
    random_traffic(300);
    drain();
    calm = 1'b0;

    set_headers(8'hFF, 8'h00);
    send_frame(8'hA5, 255, 1'b0, -1, WHOLE, 1'b0);
    random_traffic(200);
    drain();

    set_headers(8'h7E, 8'h7E);
    random_traffic(250);
    drain();

    set_headers(8'($urandom), 8'($urandom));
    random_traffic(250);
    drain();

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
